// File: rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, stage word types and root count codes of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int DW   = 32;           // coefficient and root width
  localparam int FB   = 16;           // fraction bits
  localparam int EPSW = 16;           // tolerance register width
  localparam int SQW  = DW + 1;       // square root width, one root bit per stage
  localparam int RDW  = 2 * SQW;      // discriminant width
  localparam int RW   = SQW + 3;      // square root remainder width
  localparam int DENW = DW + 1;       // divisor width
  localparam int NW   = SQW + 1;      // numerator magnitude width
  localparam int QW   = NW + FB;      // dividend and quotient width

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } root_count_e;

  typedef struct packed {
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [DW-1:0] mc;
    logic          na;
    logic          nb;
    logic          nc;
    logic          za;
    logic          zb;
    logic          zc;
  } mag_t;

  typedef struct packed {
    logic [2*DW-1:0] bb;
    logic [2*DW-1:0] ac;
    logic [DW-1:0]   ma;
    logic [DW-1:0]   mb;
    logic [DW-1:0]   mc;
    logic            na;
    logic            nb;
    logic            nc;
    logic            za;
    logic            zb;
    logic            zc;
  } prod_t;

  typedef struct packed {
    root_count_e     cnt;
    logic            lin;
    logic            lneg;
    logic            na;
    logic            nb;
    logic [DW-1:0]   mb;
    logic [DW-1:0]   mc;
    logic [DENW-1:0] den;
    logic [RDW-1:0]  rad;
    logic [RW-1:0]   rem;
    logic [SQW-1:0]  root;
  } sq_t;

  typedef struct packed {
    root_count_e     cnt;
    logic            neg1;
    logic            neg2;
    logic [DENW-1:0] den;
    logic [QW-1:0]   num1;
    logic [QW-1:0]   num2;
    logic [DENW-1:0] rem1;
    logic [DENW-1:0] rem2;
    logic [QW-1:0]   q1;
    logic [QW-1:0]   q2;
  } dv_t;

endpackage

// File: rtl/quadratic_root_solver_top.sv
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Stages: magnitude, multiply, discriminant, 33 square root steps, numerator,
//   50 divide steps (two dividers side by side), saturate into the output register.
// Reset: clears all valid bits and sets the tolerance register to 1.
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top import qrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [EPSW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [DW-1:0] coef_a_i,
  input  logic signed [DW-1:0] coef_b_i,
  input  logic signed [DW-1:0] coef_c_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           root_count_o,
  output logic signed [DW-1:0] root_one_o,
  output logic signed [DW-1:0] root_two_o,
  output logic                 saturated_o
);

  localparam logic [QW-1:0] HALF = QW'(1) << (DW - 1);

  function automatic logic [DW-1:0] mag(logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  function automatic sq_t sq_step(sq_t s);
    sq_t            r;
    logic [RW-1:0]  rem2;
    logic [RW-1:0]  trial;
    r     = s;
    rem2  = {s.rem[RW-3:0], s.rad[RDW-1 -: 2]};
    trial = RW'({s.root, 2'b01});
    r.rad = s.rad << 2;
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[SQW-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[SQW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [DENW+QW-1:0] div_step(logic [DENW-1:0] den, logic [DENW-1:0] rem,
                                                  logic [QW-1:0] q, logic [QW-1:0] num);
    logic [DENW:0]   rem2;
    logic [DENW-1:0] rn;
    logic            bit_q;
    rem2  = {rem, num[QW-1]};
    bit_q = (rem2 >= {1'b0, den});
    rn    = bit_q ? DENW'(rem2 - {1'b0, den}) : rem2[DENW-1:0];
    return {bit_q, rn, q[QW-2:0]};
  endfunction

  function automatic logic [DW:0] to_field(logic neg, logic [QW-1:0] q);
    logic [QW-1:0] lim;
    logic [DW-1:0] v;
    logic          sat;
    lim = neg ? HALF : HALF - QW'(1);
    sat = q > lim;
    v   = sat ? lim[DW-1:0] : q[DW-1:0];
    if (neg) v = -v;
    return {sat, v};
  endfunction

  logic            adv;
  logic [EPSW-1:0] eps_q;
  logic [DW-1:0]   eps_x;

  logic  a_v_q, b_v_q;
  mag_t  a_q, a_d;
  prod_t b_q;
  sq_t   c_d;
  logic  sv_q [SQW+1];
  sq_t   sq_q [SQW+1];
  logic  dvv_q [QW+1];
  dv_t   dv_q [QW+1];
  dv_t   e_d;

  logic                 out_v_q;
  root_count_e          cnt_q, cnt_d;
  logic [DW-1:0]        r1_q, r1_d, r2_q, r2_d;
  logic                 sat_q, sat_d;

  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;
  assign eps_x      = DW'(eps_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPSW'(1);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // magnitudes and near-zero tests
  always_comb begin
    a_d.ma = mag(coef_a_i);
    a_d.mb = mag(coef_b_i);
    a_d.mc = mag(coef_c_i);
    a_d.na = coef_a_i[DW-1];
    a_d.nb = coef_b_i[DW-1];
    a_d.nc = coef_c_i[DW-1];
    a_d.za = (a_d.ma == '0) || (a_d.ma < eps_x);
    a_d.zb = (a_d.mb == '0) || (a_d.mb < eps_x);
    a_d.zc = (a_d.mc == '0) || (a_d.mc < eps_x);
  end

  // discriminant, count decision, divisor
  always_comb begin
    logic [RDW-1:0] bbx;
    logic [RDW-1:0] ac4;
    logic [RDW-1:0] d;
    logic [RDW-1:0] thr;
    logic           dneg;
    logic           dsmall;
    bbx    = RDW'(b_q.bb);
    ac4    = RDW'(b_q.ac) << 2;
    thr    = RDW'({eps_q, {FB{1'b0}}});
    dneg   = (b_q.na == b_q.nc) && (bbx < ac4);
    d      = (b_q.na != b_q.nc) ? bbx + ac4 : bbx - ac4;
    dsmall = (d == '0) || (d < thr);
    if (b_q.za) begin
      if (b_q.zb) c_d.cnt = b_q.zc ? CNT_INF : CNT_NONE;
      else        c_d.cnt = CNT_ONE;
    end else if (dneg) begin
      c_d.cnt = CNT_NONE;
    end else begin
      c_d.cnt = dsmall ? CNT_ONE : CNT_TWO;
    end
    c_d.lin  = b_q.za;
    c_d.lneg = (b_q.nc == b_q.nb);
    c_d.na   = b_q.na;
    c_d.nb   = b_q.nb;
    c_d.mb   = b_q.mb;
    c_d.mc   = b_q.mc;
    c_d.den  = b_q.za ? DENW'(b_q.mb) : {b_q.ma, 1'b0};
    c_d.rad  = d;
    c_d.rem  = '0;
    c_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      sv_q[0]   <= 1'b0;
    end else if (adv) begin
      a_v_q     <= in_valid_i;
      b_v_q     <= a_v_q;
      sv_q[0]   <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q     <= a_d;
      b_q.bb  <= a_q.mb * a_q.mb;
      b_q.ac  <= a_q.ma * a_q.mc;
      b_q.ma  <= a_q.ma;
      b_q.mb  <= a_q.mb;
      b_q.mc  <= a_q.mc;
      b_q.na  <= a_q.na;
      b_q.nb  <= a_q.nb;
      b_q.nc  <= a_q.nc;
      b_q.za  <= a_q.za;
      b_q.zb  <= a_q.zb;
      b_q.zc  <= a_q.zc;
      sq_q[0] <= c_d;
    end
  end

  // square root, one root bit per stage
  for (genvar i = 0; i < SQW; i++) begin : g_sq
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i+1] <= 1'b0;
      end else if (adv) begin
        sv_q[i+1] <= sv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[i+1] <= sq_step(sq_q[i]);
      end
    end
  end

  // numerators -b +/- sqrt D, or c for the linear case
  always_comb begin
    logic [NW-1:0] mbx;
    logic [NW-1:0] sx;
    logic [NW-1:0] sum;
    logic [NW-1:0] n1;
    logic [NW-1:0] n2;
    logic          ge;
    logic          nn1;
    logic          nn2;
    mbx = NW'(sq_q[SQW].mb);
    sx  = NW'(sq_q[SQW].root);
    sum = mbx + sx;
    ge  = mbx >= sx;
    if (sq_q[SQW].nb) begin
      n1  = sum;
      nn1 = 1'b0;
      n2  = ge ? mbx - sx : sx - mbx;
      nn2 = !ge;
    end else begin
      n1  = ge ? mbx - sx : sx - mbx;
      nn1 = ge;
      n2  = sum;
      nn2 = 1'b1;
    end
    if (sq_q[SQW].lin) begin
      n1  = NW'(sq_q[SQW].mc);
      nn1 = sq_q[SQW].lneg;
    end else begin
      nn1 = nn1 ^ sq_q[SQW].na;
    end
    nn2      = nn2 ^ sq_q[SQW].na;
    e_d.cnt  = sq_q[SQW].cnt;
    e_d.neg1 = nn1;
    e_d.neg2 = nn2;
    e_d.den  = sq_q[SQW].den;
    e_d.num1 = {n1, {FB{1'b0}}};
    e_d.num2 = {n2, {FB{1'b0}}};
    e_d.rem1 = '0;
    e_d.rem2 = '0;
    e_d.q1   = '0;
    e_d.q2   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (adv) begin
      dvv_q[0] <= sv_q[SQW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= e_d;
    end
  end

  // two restoring dividers, one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_dv
    logic [DENW+QW-1:0] st1;
    logic [DENW+QW-1:0] st2;
    assign st1 = div_step(dv_q[i].den, dv_q[i].rem1, dv_q[i].q1, dv_q[i].num1);
    assign st2 = div_step(dv_q[i].den, dv_q[i].rem2, dv_q[i].q2, dv_q[i].num2);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[i+1] <= 1'b0;
      end else if (adv) begin
        dvv_q[i+1] <= dvv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[i+1].cnt  <= dv_q[i].cnt;
        dv_q[i+1].neg1 <= dv_q[i].neg1;
        dv_q[i+1].neg2 <= dv_q[i].neg2;
        dv_q[i+1].den  <= dv_q[i].den;
        dv_q[i+1].num1 <= dv_q[i].num1 << 1;
        dv_q[i+1].num2 <= dv_q[i].num2 << 1;
        dv_q[i+1].rem1 <= st1[QW-1 +: DENW];
        dv_q[i+1].rem2 <= st2[QW-1 +: DENW];
        dv_q[i+1].q1   <= {st1[QW-2:0], st1[DENW+QW-1]};
        dv_q[i+1].q2   <= {st2[QW-2:0], st2[DENW+QW-1]};
      end
    end
  end

  // saturate and drop unused roots
  always_comb begin
    logic [DW:0] f1;
    logic [DW:0] f2;
    f1    = to_field(dv_q[QW].neg1, dv_q[QW].q1);
    f2    = to_field(dv_q[QW].neg2, dv_q[QW].q2);
    cnt_d = dv_q[QW].cnt;
    r1_d  = '0;
    r2_d  = '0;
    sat_d = 1'b0;
    case (dv_q[QW].cnt)
      CNT_ONE: begin
        r1_d  = f1[DW-1:0];
        sat_d = f1[DW];
      end
      CNT_TWO: begin
        r1_d  = f1[DW-1:0];
        r2_d  = f2[DW-1:0];
        sat_d = f1[DW] | f2[DW];
      end
      default: begin
        r1_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dvv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt_q <= cnt_d;
      r1_q  <= r1_d;
      r2_q  <= r2_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign root_count_o = cnt_q;
  assign root_one_o   = r1_q;
  assign root_two_o   = r2_q;
  assign saturated_o  = sat_q;

  a_no_root_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (cnt_q == CNT_NONE || cnt_q == CNT_INF)
    |-> (r1_q == '0) && (r2_q == '0) && !sat_q)
    else $error("roots not cleared for count none or infinite");

  a_one_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (cnt_q == CNT_ONE) |-> (r2_q == '0))
    else $error("second root set for single root");

  a_sat_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && sat_q
    |-> (r1_q == HALF[DW-1:0]) || (r1_q == HALF[DW-1:0] - DW'(1))
     || (r2_q == HALF[DW-1:0]) || (r2_q == HALF[DW-1:0] - DW'(1)))
    else $error("saturation flag without a clipped root");

endmodule
